FILE: design/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared widths, constants and types of the four-channel compare/capture timer.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int COUNT_WIDTH  = 32;
  localparam int NUM_CH       = 4;
  localparam int ADDR_WIDTH   = 8;
  localparam int DATA_WIDTH   = 32;
  localparam logic [ADDR_WIDTH-1:0] CC_BASE_ADDR = 8'd0;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [NUM_CH-1:0]      ch_mask_t;
  typedef logic [ADDR_WIDTH-1:0]  addr_t;
  typedef logic [DATA_WIDTH-1:0]  data_t;

  // address of compare channel n on the register bus
  function automatic addr_t cc_addr(input int unsigned n);
    cc_addr = CC_BASE_ADDR + ADDR_WIDTH'(n);
  endfunction

endpackage

FILE: design/tcc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_in_if
// Tick channel into the timer: one item per clock tick with tasks and bus write.
// ----------------------------------------------------------------------------
interface tcc_in_if;
  logic                    valid;
  logic                    ready;
  logic                    us_pulse;
  logic                    start_task;
  logic                    stop_task;
  logic                    clear_task;
  tcc_pkg::ch_mask_t       capture_tasks;
  logic                    bus_select;
  logic                    bus_write;
  tcc_pkg::addr_t          write_address;
  tcc_pkg::data_t          write_data;

  modport source (
    output valid, us_pulse, start_task, stop_task, clear_task, capture_tasks,
           bus_select, bus_write, write_address, write_data,
    input  ready
  );

  modport sink (
    input  valid, us_pulse, start_task, stop_task, clear_task, capture_tasks,
           bus_select, bus_write, write_address, write_data,
    output ready
  );
endinterface

FILE: design/tcc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_out_if
// Result channel of the timer: compare events, count and running flag per tick.
// ----------------------------------------------------------------------------
interface tcc_out_if;
  logic                    valid;
  logic                    ready;
  tcc_pkg::ch_mask_t       compare_events;
  logic [31:0]             count_value;
  logic                    running;

  modport source (
    output valid, compare_events, count_value, running,
    input  ready
  );

  modport sink (
    input  valid, compare_events, count_value, running,
    output ready
  );
endinterface

FILE: design/timer_compare_capture_4ch_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_compare_capture_4ch_core
// Cycle-exact timer with start/stop/clear tasks and four compare/capture regs.
// ----------------------------------------------------------------------------
// usage
//   in_chan  : one item per timer tick (us pulse, task pulses, capture mask,
//              one register bus write). accepted when valid and ready are high.
//   out_chan : one item per accepted tick: compare events, count and running
//              flag as they stood before that tick's update.
//   result   : the result is registered, it appears in the cycle after the tick
//              is accepted.
//   rate     : one tick per cycle while results are taken (see stall); each
//              tick is handled by the compare and next-state logic between
//              the state registers and the result register.
//   stall    : a waiting result is held in the result register; the next tick
//              is still taken in the cycle the receiver takes that result, so
//              in_chan.ready falls only while a result sits and out ready is low.
//   reset    : rst_n (synchronous, active low) stops the timer, clears the
//              counter, the pending task flags, all compare registers and the
//              result valid flag.
// ----------------------------------------------------------------------------
module timer_compare_capture_4ch_core (
  input  logic         clk,
  input  logic         rst_n,
  tcc_in_if.sink       in_chan,
  tcc_out_if.source    out_chan
);

  logic                start_pend_r, start_pend_nxt;
  logic                stop_pend_r,  stop_pend_nxt;
  logic                clear_pend_r, clear_pend_nxt;
  logic                run_r,        run_nxt;
  tcc_pkg::cnt_t       cnt_r,        cnt_nxt;
  tcc_pkg::cnt_t       cc_r   [tcc_pkg::NUM_CH];
  tcc_pkg::cnt_t       cc_nxt [tcc_pkg::NUM_CH];

  logic                out_valid_r;
  tcc_pkg::ch_mask_t   out_events_r, out_events_nxt;
  logic [31:0]         out_count_r;
  logic                out_run_r;

  logic                accept;
  logic                bus_wr;
  tcc_pkg::cnt_t       wr_data;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign bus_wr        = in_chan.bus_select && in_chan.bus_write;
  assign wr_data       = in_chan.write_data[tcc_pkg::COUNT_WIDTH-1:0];

  always_comb begin
    // pending flags act on their old value at the us pulse
    run_nxt = run_r;
    if (start_pend_r && in_chan.us_pulse) begin
      run_nxt = 1'b1;
    end else if (stop_pend_r && in_chan.us_pulse) begin
      run_nxt = 1'b0;
    end

    cnt_nxt = cnt_r;
    if (run_r) begin
      if (clear_pend_r && in_chan.us_pulse) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + tcc_pkg::COUNT_WIDTH'(1);
      end
    end

    start_pend_nxt = in_chan.start_task || (!in_chan.us_pulse && start_pend_r);
    stop_pend_nxt  = in_chan.stop_task  || (!in_chan.us_pulse && stop_pend_r);
    clear_pend_nxt = in_chan.clear_task || (!in_chan.us_pulse && clear_pend_r);

    for (int n = 0; n < tcc_pkg::NUM_CH; n++) begin
      out_events_nxt[n] = run_r && (cc_r[n] == cnt_r);
      // bus write wins over capture
      if (bus_wr && (in_chan.write_address == tcc_pkg::cc_addr(n))) begin
        cc_nxt[n] = wr_data;
      end else if (in_chan.capture_tasks[n]) begin
        cc_nxt[n] = cnt_r;
      end else begin
        cc_nxt[n] = cc_r[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pend_r <= 1'b0;
      stop_pend_r  <= 1'b0;
      clear_pend_r <= 1'b0;
      run_r        <= 1'b0;
      cnt_r        <= '0;
      for (int n = 0; n < tcc_pkg::NUM_CH; n++) begin
        cc_r[n] <= '0;
      end
    end else if (accept) begin
      start_pend_r <= start_pend_nxt;
      stop_pend_r  <= stop_pend_nxt;
      clear_pend_r <= clear_pend_nxt;
      run_r        <= run_nxt;
      cnt_r        <= cnt_nxt;
      for (int n = 0; n < tcc_pkg::NUM_CH; n++) begin
        cc_r[n] <= cc_nxt[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_events_r <= out_events_nxt;
      out_count_r  <= 32'(cnt_r);
      out_run_r    <= run_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.compare_events = out_events_r;
  assign out_chan.count_value    = out_count_r;
  assign out_chan.running        = out_run_r;

endmodule
